### rtl/core/aligned_bump_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the aligned bump allocator
// Same-cycle and next-cycle implications, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_BUMP_ALLOCATOR_UNIT_ASSERT_SVH
`define ALIGNED_BUMP_ALLOCATOR_UNIT_ASSERT_SVH

// ante implies cons in the same cycle
`define ABUMP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define ABUMP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/abump_pkg.sv
// ----------------------------------------------------------------------------
// abump_pkg
// Shared types and constants of the aligned bump allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abump_pkg;

  localparam int FIELD_BITS     = 32;
  localparam int CMD_BITS       = 2;
  localparam int ERR_BITS       = 3;
  localparam int CFG_INDEX_BITS = 1;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_BASE    = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY_BYTES = 1'b1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_OK       = 3'd0,
    ERR_INVALID  = 3'd1,
    ERR_ALIGN    = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_CAPACITY = 3'd4
  } err_t;

  // per-request flags passed from the front stage to the allocation stage
  typedef struct packed {
    cmd_t cmd;
    logic mul_ovf;
    logic align_bad;
  } prep_flags_t;

  // result word
  typedef struct packed {
    logic                  ok;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] block_address;
    err_t                  error_code;
  } rsp_word_t;

endpackage

### rtl/core/abump_if.sv
// ----------------------------------------------------------------------------
// abump channel interfaces
// Request, response and configuration write channels (valid/ready).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abump_req_if;
  logic                             valid;
  logic                             ready;
  logic [abump_pkg::CMD_BITS-1:0]   command;
  logic [abump_pkg::FIELD_BITS-1:0] item_count;
  logic [abump_pkg::FIELD_BITS-1:0] elem_bytes;
  logic [abump_pkg::FIELD_BITS-1:0] alignment;

  modport source (output valid, command, item_count, elem_bytes, alignment,
                  input ready);
  modport sink   (input valid, command, item_count, elem_bytes, alignment,
                  output ready);
endinterface

interface abump_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [abump_pkg::FIELD_BITS-1:0] offset;
  logic [abump_pkg::FIELD_BITS-1:0] block_address;
  logic [abump_pkg::ERR_BITS-1:0]   error_code;

  modport source (output valid, ok, offset, block_address, error_code,
                  input ready);
  modport sink   (input valid, ok, offset, block_address, error_code,
                  output ready);
endinterface

interface abump_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [abump_pkg::CFG_INDEX_BITS-1:0] index;
  logic [abump_pkg::FIELD_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/abump_front.sv
// ----------------------------------------------------------------------------
// abump_front
// Input register, size multiply and alignment decode into the prep register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abump_front #(
  parameter int ADDR_BITS = 32
) (
  input  logic                             clk,
  input  logic                             load_in,
  input  logic                             load_prep,
  input  logic [abump_pkg::CMD_BITS-1:0]   command,
  input  logic [abump_pkg::FIELD_BITS-1:0] item_count,
  input  logic [abump_pkg::FIELD_BITS-1:0] elem_bytes,
  input  logic [abump_pkg::FIELD_BITS-1:0] alignment,
  output abump_pkg::prep_flags_t           flags,
  output logic [ADDR_BITS-1:0]             size,
  output logic [ADDR_BITS-1:0]             align_mask
);

  // operands are cut to the narrower of the field and the address width
  localparam int OP_BITS   = (ADDR_BITS < abump_pkg::FIELD_BITS) ?
                             ADDR_BITS : abump_pkg::FIELD_BITS;
  localparam int PROD_BITS = 2 * OP_BITS;

  logic [abump_pkg::CMD_BITS-1:0] cmd_q;
  logic [OP_BITS-1:0]             count_q;
  logic [OP_BITS-1:0]             esize_q;
  logic [OP_BITS-1:0]             align_q;

  logic [PROD_BITS-1:0]           prod;
  logic [ADDR_BITS-1:0]           align_w;
  logic [ADDR_BITS-1:0]           mask_w;
  abump_pkg::prep_flags_t         flags_next;

  always_ff @(posedge clk) begin
    if (load_in) begin
      cmd_q   <= command;
      count_q <= OP_BITS'(item_count);
      esize_q <= OP_BITS'(elem_bytes);
      align_q <= OP_BITS'(alignment);
    end
  end

  always_comb begin
    prod                 = PROD_BITS'(count_q) * PROD_BITS'(esize_q);
    align_w              = ADDR_BITS'(align_q);
    mask_w               = align_w - ADDR_BITS'(1);
    flags_next.cmd       = abump_pkg::cmd_t'(cmd_q);
    // product bits above the address width mean the block cannot exist
    flags_next.mul_ovf   = |(prod >> ADDR_BITS);
    flags_next.align_bad = (align_w == '0) || ((align_w & mask_w) != '0);
  end

  always_ff @(posedge clk) begin
    if (load_prep) begin
      flags      <= flags_next;
      size       <= ADDR_BITS'(prod);
      align_mask <= mask_w;
    end
  end

endmodule

### rtl/core/abump_core.sv
// ----------------------------------------------------------------------------
// abump_core
// Region registers, cursor, sticky error and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abump_core #(
  parameter int ADDR_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [abump_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [abump_pkg::FIELD_BITS-1:0]     cfg_data,
  input  logic                                 step,
  input  abump_pkg::prep_flags_t               flags,
  input  logic [ADDR_BITS-1:0]                 size,
  input  logic [ADDR_BITS-1:0]                 align_mask,
  output abump_pkg::rsp_word_t                 rsp_word
);

  logic [abump_pkg::FIELD_BITS-1:0] region_base;
  logic [abump_pkg::FIELD_BITS-1:0] capacity_bytes;
  logic [ADDR_BITS-1:0]             cursor;
  abump_pkg::err_t                  sticky_error;

  logic [ADDR_BITS-1:0]             cursor_next;
  abump_pkg::err_t                  sticky_error_next;
  abump_pkg::rsp_word_t             rsp_word_next;

  logic [ADDR_BITS-1:0] base_w;
  logic [ADDR_BITS-1:0] cap_w;
  logic [ADDR_BITS-1:0] address;
  logic [ADDR_BITS-1:0] padding;
  logic [ADDR_BITS-1:0] aligned;
  logic [ADDR_BITS-1:0] size_eff;
  logic [ADDR_BITS-1:0] where;
  abump_pkg::err_t      start_err;
  abump_pkg::err_t      app_err;
  abump_pkg::err_t      report;
  logic                 app_ok;
  logic                 good;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base    <= '0;
      capacity_bytes <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abump_pkg::CFG_REGION_BASE:    region_base    <= cfg_data;
        abump_pkg::CFG_CAPACITY_BYTES: capacity_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // allocation checks, in the order the first error must be found
  always_comb begin
    base_w   = ADDR_BITS'(region_base);
    cap_w    = ADDR_BITS'(capacity_bytes);
    address  = base_w + cursor;
    padding  = (ADDR_BITS'(0) - address) & align_mask;
    aligned  = cursor + padding;
    size_eff = (flags.cmd == abump_pkg::CMD_FINISH) ? '0 : size;

    if ((base_w == '0) || (cap_w == '0)) begin
      start_err = abump_pkg::ERR_INVALID;
    end else if ((cap_w - ADDR_BITS'(1)) > ~base_w) begin
      start_err = abump_pkg::ERR_OVERFLOW;
    end else begin
      start_err = abump_pkg::ERR_OK;
    end

    app_ok = 1'b0;
    if (sticky_error != abump_pkg::ERR_OK) begin
      app_err = sticky_error;
    end else if (flags.align_bad) begin
      app_err = abump_pkg::ERR_ALIGN;
    end else if (cursor > cap_w) begin
      app_err = abump_pkg::ERR_CAPACITY;
    end else if (cursor > ~base_w) begin
      app_err = abump_pkg::ERR_OVERFLOW;
    end else if (padding > (cap_w - cursor)) begin
      app_err = abump_pkg::ERR_CAPACITY;
    end else if (size_eff > (cap_w - aligned)) begin
      app_err = abump_pkg::ERR_CAPACITY;
    end else begin
      app_err = abump_pkg::ERR_OK;
      app_ok  = 1'b1;
    end
  end

  always_comb begin
    cursor_next       = cursor;
    sticky_error_next = sticky_error;
    good              = 1'b0;
    where             = '0;
    report            = abump_pkg::ERR_INVALID;

    unique case (flags.cmd)
      abump_pkg::CMD_START: begin
        cursor_next       = '0;
        sticky_error_next = start_err;
        good              = (start_err == abump_pkg::ERR_OK);
        report            = start_err;
      end
      abump_pkg::CMD_APPEND: begin
        if (flags.mul_ovf) begin
          if (sticky_error == abump_pkg::ERR_OK) begin
            sticky_error_next = abump_pkg::ERR_OVERFLOW;
          end
        end else if (app_ok) begin
          cursor_next = aligned + size_eff;
          good        = 1'b1;
          where       = aligned;
        end else begin
          sticky_error_next = app_err;
        end
        report = sticky_error_next;
      end
      abump_pkg::CMD_FINISH: begin
        if (app_ok) begin
          cursor_next = aligned;
          good        = 1'b1;
          where       = aligned;
        end else begin
          sticky_error_next = app_err;
        end
        report = sticky_error_next;
      end
      default: ;  // reserved command: report invalid, hold state
    endcase

    rsp_word_next.ok            = good;
    rsp_word_next.offset        = abump_pkg::FIELD_BITS'(where);
    rsp_word_next.block_address = good ?
                                  abump_pkg::FIELD_BITS'(base_w + where) : '0;
    if (good) begin
      rsp_word_next.error_code = abump_pkg::ERR_OK;
    end else if (report == abump_pkg::ERR_OK) begin
      rsp_word_next.error_code = abump_pkg::ERR_INVALID;
    end else begin
      rsp_word_next.error_code = report;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      sticky_error <= abump_pkg::ERR_INVALID;
    end else if (step) begin
      cursor       <= cursor_next;
      sticky_error <= sticky_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_word <= rsp_word_next;
    end
  end

endmodule

### rtl/core/aligned_bump_allocator_unit.sv
// A request is taken into the input register, then the prep and result registers.
// Throughput: one request per cycle unless the output stalls; the size
// multiply has its own stage and the cursor update closes in the allocation
// stage, so requests stream. Output back-pressure holds a stage only while
// every stage after it is full. Reset: cursor cleared, sticky error set to
// invalid argument until a start, region registers cleared, pipeline emptied.
// ----------------------------------------------------------------------------
// aligned_bump_allocator_unit
// Linear arena allocator with power-of-two alignment, three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aligned_bump_allocator_unit_assert.svh"

module aligned_bump_allocator_unit #(
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  abump_cfg_if.sink   cfg,
  abump_req_if.sink   req,
  abump_rsp_if.source rsp
);

  logic i_valid;
  logic p_valid;
  logic r_valid;
  logic r_free;
  logic p_free;
  logic p_go;
  logic i_go;
  logic accept;

  abump_pkg::prep_flags_t flags;
  logic [ADDR_BITS-1:0]   size;
  logic [ADDR_BITS-1:0]   align_mask;
  abump_pkg::rsp_word_t   rsp_word;

  // stall chain from the output back to the input
  assign r_free    = !r_valid || rsp.ready;
  assign p_go      = p_valid && r_free;
  assign p_free    = !p_valid || r_free;
  assign i_go      = i_valid && p_free;
  assign req.ready = !i_valid || p_free;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
      p_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      if (accept) begin
        i_valid <= 1'b1;
      end else if (i_go) begin
        i_valid <= 1'b0;
      end
      if (i_go) begin
        p_valid <= 1'b1;
      end else if (p_go) begin
        p_valid <= 1'b0;
      end
      if (p_go) begin
        r_valid <= 1'b1;
      end else if (rsp.ready) begin
        r_valid <= 1'b0;
      end
    end
  end

  abump_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk          (clk),
    .load_in      (accept),
    .load_prep    (i_go),
    .command      (req.command),
    .item_count   (req.item_count),
    .elem_bytes   (req.elem_bytes),
    .alignment    (req.alignment),
    .flags        (flags),
    .size         (size),
    .align_mask   (align_mask)
  );

  abump_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .step       (p_go),
    .flags      (flags),
    .size       (size),
    .align_mask (align_mask),
    .rsp_word   (rsp_word)
  );

  assign rsp.valid         = r_valid;
  assign rsp.ok            = rsp_word.ok;
  assign rsp.offset        = rsp_word.offset;
  assign rsp.block_address = rsp_word.block_address;
  assign rsp.error_code    = rsp_word.error_code;

  `ABUMP_ASSERT_NEXT(a_step_fills_result, clk, rst, p_go, r_valid,
                     "allocation step lost its result")
  `ABUMP_ASSERT_SAME(a_ok_means_no_error, clk, rst, r_valid && rsp_word.ok,
                     rsp_word.error_code == abump_pkg::ERR_OK,
                     "ok word carries an error code")
  `ABUMP_ASSERT_NEXT(a_stalled_input_held, clk, rst, i_valid && !p_free, i_valid,
                     "stalled input word dropped")
  `ABUMP_ASSERT_SAME(a_ready_low_only_full, clk, rst, !req.ready,
                     i_valid && p_valid && r_valid,
                     "input stalled with room in the pipeline")

endmodule
